[hdl/pal_pkg.sv]
// ----------------------------------------------------------------------------
// pal_pkg: shared types and constants for the positional array list
// Sizes, operation and status codes, and the structs that run between the
// decoder, the cell row and the top level.
// ----------------------------------------------------------------------------
package pal_pkg;

    localparam int CAPACITY  = 64;
    localparam int WORD_BITS = 32;

    // fixed field widths of the ports
    localparam int MODE_BITS  = 3;
    localparam int POS_BITS   = 7;
    localparam int ITEM_BITS  = 32;
    localparam int STAT_BITS  = 2;
    localparam int COUNT_BITS = 7;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CMP_W = (CNT_W > POS_BITS) ? CNT_W : POS_BITS;

    // read-out tree: groups of cells ORed in the first stage
    localparam int GROUP      = 8;
    localparam int NUM_GROUPS = (CAPACITY + GROUP - 1) / GROUP;

    typedef enum logic [MODE_BITS-1:0] {
        MODE_PUSH_BACK  = 3'd0,
        MODE_PUSH_FRONT = 3'd1,
        MODE_INSERT     = 3'd2,
        MODE_ERASE      = 3'd3,
        MODE_POP_BACK   = 3'd4,
        MODE_POP_FRONT  = 3'd5,
        MODE_READ       = 3'd6,
        MODE_CLEAR      = 3'd7
    } t_mode;

    typedef enum logic [STAT_BITS-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    // broadcast to every cell on an accepted transfer
    typedef struct packed {
        logic                 ins;
        logic                 rem;
        logic [IDX_W-1:0]     at;
        logic [WORD_BITS-1:0] word;
    } t_cell_cmd;

    // read select, in the cycle after the transfer
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] pos;
    } t_cell_rd;

    // per-item result of the decoder
    typedef struct packed {
        t_status          status;
        logic [CNT_W-1:0] count;
        logic             rd;
        logic [IDX_W-1:0] pos;
    } t_ctrl_res;

endpackage

[hdl/pal_cell.sv]
// ----------------------------------------------------------------------------
// pal_cell: one list entry
// Holds one word; loads, takes its left neighbor (insert) or its right
// neighbor (removal) as the broadcast command says, and drives its word on
// the read lines when selected.
// ----------------------------------------------------------------------------
module pal_cell (
    input  logic                          i_clk,
    input  logic [pal_pkg::IDX_W-1:0]     i_idx,
    input  pal_pkg::t_cell_cmd            i_cmd,
    input  pal_pkg::t_cell_rd             i_rd,
    input  logic [pal_pkg::WORD_BITS-1:0] i_left,
    input  logic [pal_pkg::WORD_BITS-1:0] i_right,
    output logic [pal_pkg::WORD_BITS-1:0] o_word,
    output logic [pal_pkg::WORD_BITS-1:0] o_rd_word
);

    logic [pal_pkg::WORD_BITS-1:0] r_word;
    logic [pal_pkg::WORD_BITS-1:0] n_word;

    always_comb begin
        n_word = r_word;
        if (i_cmd.ins) begin
            if (i_idx == i_cmd.at) begin
                n_word = i_cmd.word;
            end else if (i_idx > i_cmd.at) begin
                n_word = i_left;
            end
        end else if (i_cmd.rem && (i_idx >= i_cmd.at)) begin
            n_word = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word    = r_word;
    assign o_rd_word = (i_rd.en && (i_rd.pos == i_idx)) ? r_word : '0;

endmodule

[hdl/pal_ctrl.sv]
// ----------------------------------------------------------------------------
// pal_ctrl: operation decoder
// Checks an incoming operation against the current count, picks the status
// and new count, and builds the shift command for the cell row.
// ----------------------------------------------------------------------------
module pal_ctrl (
    input  logic [pal_pkg::MODE_BITS-1:0] i_mode,
    input  logic [pal_pkg::POS_BITS-1:0]  i_position,
    input  logic [pal_pkg::ITEM_BITS-1:0] i_item_word,
    input  logic [pal_pkg::CNT_W-1:0]     i_count,
    output pal_pkg::t_cell_cmd            o_cmd,
    output pal_pkg::t_ctrl_res            o_res
);

    logic [pal_pkg::CMP_W-1:0] w_pos;
    logic [pal_pkg::CMP_W-1:0] w_cnt;
    logic                      w_full;
    logic                      w_empty;

    assign w_pos   = pal_pkg::CMP_W'(i_position);
    assign w_cnt   = pal_pkg::CMP_W'(i_count);
    assign w_full  = (w_cnt >= pal_pkg::CMP_W'(pal_pkg::CAPACITY));
    assign w_empty = (i_count == '0);

    always_comb begin
        o_cmd        = '0;
        o_cmd.word   = pal_pkg::WORD_BITS'(i_item_word);
        o_res.status = pal_pkg::ST_OK;
        o_res.count  = i_count;
        o_res.rd     = 1'b0;
        o_res.pos    = pal_pkg::IDX_W'(i_position);
        unique case (pal_pkg::t_mode'(i_mode))
            pal_pkg::MODE_PUSH_BACK: begin
                if (w_full) begin
                    o_res.status = pal_pkg::ST_FULL;
                end else begin
                    o_cmd.ins   = 1'b1;
                    o_cmd.at    = pal_pkg::IDX_W'(i_count);
                    o_res.count = i_count + 1'b1;
                end
            end
            pal_pkg::MODE_PUSH_FRONT: begin
                if (w_full) begin
                    o_res.status = pal_pkg::ST_FULL;
                end else begin
                    o_cmd.ins   = 1'b1;
                    o_res.count = i_count + 1'b1;
                end
            end
            pal_pkg::MODE_INSERT: begin
                // range is checked before fullness
                if (w_pos > w_cnt) begin
                    o_res.status = pal_pkg::ST_RANGE;
                end else if (w_full) begin
                    o_res.status = pal_pkg::ST_FULL;
                end else begin
                    o_cmd.ins   = 1'b1;
                    o_cmd.at    = pal_pkg::IDX_W'(i_position);
                    o_res.count = i_count + 1'b1;
                end
            end
            pal_pkg::MODE_ERASE: begin
                if (w_empty) begin
                    o_res.status = pal_pkg::ST_EMPTY;
                end else if (w_pos >= w_cnt) begin
                    o_res.status = pal_pkg::ST_RANGE;
                end else begin
                    o_cmd.rem   = 1'b1;
                    o_cmd.at    = pal_pkg::IDX_W'(i_position);
                    o_res.count = i_count - 1'b1;
                end
            end
            pal_pkg::MODE_POP_BACK: begin
                if (w_empty) begin
                    o_res.status = pal_pkg::ST_EMPTY;
                end else begin
                    o_res.count = i_count - 1'b1;
                end
            end
            pal_pkg::MODE_POP_FRONT: begin
                if (w_empty) begin
                    o_res.status = pal_pkg::ST_EMPTY;
                end else begin
                    o_cmd.rem   = 1'b1;
                    o_res.count = i_count - 1'b1;
                end
            end
            pal_pkg::MODE_READ: begin
                if (w_empty) begin
                    o_res.status = pal_pkg::ST_EMPTY;
                end else if (w_pos >= w_cnt) begin
                    o_res.status = pal_pkg::ST_RANGE;
                end else begin
                    o_res.rd = 1'b1;
                end
            end
            pal_pkg::MODE_CLEAR: begin
                o_res.count = '0;
            end
            default: begin
                o_res.count = i_count;
            end
        endcase
    end

endmodule

[hdl/positional_array_list.sv]
// ----------------------------------------------------------------------------
// positional_array_list: ordered list of up to CAPACITY words
//
//   channel   direction   handshake                   payload
//   in        to block    i_in_valid / o_in_ready     i_mode, i_position, i_item_word
//   out       from block  o_out_valid / i_out_ready   o_status, o_entry_count,
//                                                     o_read_word
//
// One item per cycle while the output is not stalled; each result is registered
// in stage 1, stage 2 and the output register. The whole cell row shifts in the
// cycle of the input transfer; reads go through a registered OR tree over the cells.
// Reset clears the count and the pipeline valids; cell contents are kept.
// A stalled output backs up through the two read stages before o_in_ready drops.
// ----------------------------------------------------------------------------
module positional_array_list (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [pal_pkg::MODE_BITS-1:0]  i_mode,
    input  logic [pal_pkg::POS_BITS-1:0]   i_position,
    input  logic [pal_pkg::ITEM_BITS-1:0]  i_item_word,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [pal_pkg::STAT_BITS-1:0]  o_status,
    output logic [pal_pkg::COUNT_BITS-1:0] o_entry_count,
    output logic [pal_pkg::ITEM_BITS-1:0]  o_read_word
);

    localparam int PAD = pal_pkg::NUM_GROUPS * pal_pkg::GROUP;

    logic [pal_pkg::CNT_W-1:0] r_count;

    // stage 1: decoded result, read select on the cells
    logic                      r_s1_valid;
    pal_pkg::t_ctrl_res        r_s1;
    // stage 2: group ORs
    logic                      r_s2_valid;
    pal_pkg::t_status          r_s2_status;
    logic [pal_pkg::CNT_W-1:0] r_s2_count;
    logic [pal_pkg::WORD_BITS-1:0] r_s2_grp [pal_pkg::NUM_GROUPS];
    logic [pal_pkg::WORD_BITS-1:0] n_s2_grp [pal_pkg::NUM_GROUPS];
    // output register
    logic                          r_out_valid;
    pal_pkg::t_status              r_out_status;
    logic [pal_pkg::CNT_W-1:0]     r_out_count;
    logic [pal_pkg::WORD_BITS-1:0] r_out_word;
    logic [pal_pkg::WORD_BITS-1:0] n_out_word;

    logic w_out_free, w_s2_move, w_s2_free, w_s1_move, w_s1_free, w_accept;

    pal_pkg::t_cell_cmd w_dec_cmd;
    pal_pkg::t_cell_cmd w_cmd;
    pal_pkg::t_ctrl_res w_res;
    pal_pkg::t_cell_rd  w_rd;

    logic [pal_pkg::WORD_BITS-1:0] w_word [pal_pkg::CAPACITY];
    logic [pal_pkg::WORD_BITS-1:0] w_rdw  [PAD];

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_s2_move  = r_s2_valid && w_out_free;
    assign w_s2_free  = !r_s2_valid || w_s2_move;
    assign w_s1_move  = r_s1_valid && w_s2_free;
    assign w_s1_free  = !r_s1_valid || w_s1_move;
    assign w_accept   = i_in_valid && w_s1_free;
    assign o_in_ready = w_s1_free;

    pal_ctrl u_ctrl (
        .i_mode      (i_mode),
        .i_position  (i_position),
        .i_item_word (i_item_word),
        .i_count     (r_count),
        .o_cmd       (w_dec_cmd),
        .o_res       (w_res)
    );

    always_comb begin
        w_cmd     = w_dec_cmd;
        w_cmd.ins = w_dec_cmd.ins && w_accept;
        w_cmd.rem = w_dec_cmd.rem && w_accept;
    end

    assign w_rd.en  = r_s1_valid && r_s1.rd;
    assign w_rd.pos = r_s1.pos;

    genvar gi;
    generate
        for (gi = 0; gi < pal_pkg::CAPACITY; gi++) begin : g_cell
            logic [pal_pkg::WORD_BITS-1:0] w_left;
            logic [pal_pkg::WORD_BITS-1:0] w_right;
            if (gi == 0) begin : g_first
                assign w_left = '0;
            end else begin : g_mid_l
                assign w_left = w_word[gi-1];
            end
            if (gi == pal_pkg::CAPACITY - 1) begin : g_last
                assign w_right = '0;
            end else begin : g_mid_r
                assign w_right = w_word[gi+1];
            end
            pal_cell u_cell (
                .i_clk     (i_clk),
                .i_idx     (pal_pkg::IDX_W'(gi)),
                .i_cmd     (w_cmd),
                .i_rd      (w_rd),
                .i_left    (w_left),
                .i_right   (w_right),
                .o_word    (w_word[gi]),
                .o_rd_word (w_rdw[gi])
            );
        end
        for (gi = pal_pkg::CAPACITY; gi < PAD; gi++) begin : g_pad
            assign w_rdw[gi] = '0;
        end
    endgenerate

    // first level of the read tree: unselected cells drive zero
    always_comb begin
        for (int g = 0; g < pal_pkg::NUM_GROUPS; g++) begin
            n_s2_grp[g] = '0;
            for (int k = 0; k < pal_pkg::GROUP; k++) begin
                n_s2_grp[g] = n_s2_grp[g] | w_rdw[g * pal_pkg::GROUP + k];
            end
        end
    end

    always_comb begin
        n_out_word = '0;
        for (int g = 0; g < pal_pkg::NUM_GROUPS; g++) begin
            n_out_word = n_out_word | r_s2_grp[g];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count <= w_res.count;
            end
            if (w_s1_free) begin
                r_s1_valid <= i_in_valid;
            end
            if (w_s2_free) begin
                r_s2_valid <= r_s1_valid;
            end
            if (w_out_free) begin
                r_out_valid <= r_s2_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1 <= w_res;
        end
        if (w_s1_move) begin
            r_s2_status <= r_s1.status;
            r_s2_count  <= r_s1.count;
            r_s2_grp    <= n_s2_grp;
        end
        if (w_s2_move) begin
            r_out_status <= r_s2_status;
            r_out_count  <= r_s2_count;
            r_out_word   <= n_out_word;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_entry_count = pal_pkg::COUNT_BITS'(r_out_count);
    assign o_read_word   = pal_pkg::ITEM_BITS'(r_out_word);

endmodule

[hdl/pal_checker.sv]
// ----------------------------------------------------------------------------
// pal_checker: port-level checks for the positional array list
// Watches the output channel and the reported status against the count.
// ----------------------------------------------------------------------------
module pal_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_out_valid,
    input logic                           i_out_ready,
    input logic [pal_pkg::STAT_BITS-1:0]  o_status,
    input logic [pal_pkg::COUNT_BITS-1:0] o_entry_count,
    input logic [pal_pkg::ITEM_BITS-1:0]  o_read_word
);

    // a stalled result stays up
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output transfer dropped while stalled");

    // full is only reported at capacity
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == pal_pkg::ST_FULL)
        |-> (o_entry_count == pal_pkg::COUNT_BITS'(pal_pkg::CAPACITY)))
        else $error("full status with count below capacity");

    // empty is only reported with no entries
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == pal_pkg::ST_EMPTY) |-> (o_entry_count == '0))
        else $error("empty status with nonzero count");

    // rejected operations never return data
    a_word_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_read_word != '0) |-> (o_status == pal_pkg::ST_OK))
        else $error("read word on a rejected operation");

    // nothing comes out right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind positional_array_list pal_checker u_pal_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_status      (o_status),
    .o_entry_count (o_entry_count),
    .o_read_word   (o_read_word)
);

[tb/sv/pal_list_checker.sv]
// ----------------------------------------------------------------------------
// pal_list_checker: scoreboard for the positional array list
// Watches both channels. Each input transfer runs through a local model of
// the list, and the expected result is queued. Each output transfer is
// compared field by field against the oldest queued result.
// ----------------------------------------------------------------------------
module pal_list_checker
    import pal_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic [MODE_BITS-1:0]  i_mode,
    input  logic [POS_BITS-1:0]   i_position,
    input  logic [ITEM_BITS-1:0]  i_item_word,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic [STAT_BITS-1:0]  i_status,
    input  logic [COUNT_BITS-1:0] i_entry_count,
    input  logic [ITEM_BITS-1:0]  i_read_word,
    output int                    o_fail_count,
    output int                    o_results_due,
    output int                    o_list_len
);

    typedef struct packed {
        t_status                status;
        logic [COUNT_BITS-1:0]  count;
        logic [ITEM_BITS-1:0]   word;
    } t_list_result;

    logic [WORD_BITS-1:0] list_words [CAPACITY];
    int                   list_len = 0;
    int                   fail_count = 0;
    t_list_result         due_results [$];
    t_list_result         want;

    // applies one operation to the local list and returns its result
    function automatic t_list_result apply_list_op(t_mode op, int pos,
                                                   logic [ITEM_BITS-1:0] word);
        t_list_result res;
        int           open_at;
        int           close_at;
        res.status = ST_OK;
        res.word   = '0;
        open_at    = -1;
        close_at   = -1;
        case (op)
            MODE_PUSH_BACK, MODE_PUSH_FRONT: begin
                if (list_len >= CAPACITY) res.status = ST_FULL;
                else open_at = (op == MODE_PUSH_BACK) ? list_len : 0;
            end
            MODE_INSERT: begin
                // position is checked ahead of fullness
                if (pos > list_len) res.status = ST_RANGE;
                else if (list_len >= CAPACITY) res.status = ST_FULL;
                else open_at = pos;
            end
            MODE_ERASE: begin
                if (list_len == 0) res.status = ST_EMPTY;
                else if (pos >= list_len) res.status = ST_RANGE;
                else close_at = pos;
            end
            MODE_POP_BACK: begin
                if (list_len == 0) res.status = ST_EMPTY;
                else list_len--;
            end
            MODE_POP_FRONT: begin
                if (list_len == 0) res.status = ST_EMPTY;
                else close_at = 0;
            end
            MODE_READ: begin
                if (list_len == 0) res.status = ST_EMPTY;
                else if (pos >= list_len) res.status = ST_RANGE;
                else res.word = list_words[pos];
            end
            MODE_CLEAR: list_len = 0;
            default: list_len = 0;
        endcase
        if (open_at >= 0) begin
            for (int i = list_len; i > open_at; i--) list_words[i] = list_words[i-1];
            list_words[open_at] = word;
            list_len++;
        end
        if (close_at >= 0) begin
            for (int i = close_at; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
            list_len--;
        end
        res.count = list_len[COUNT_BITS-1:0];
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            list_len = 0;
            due_results.delete();
        end else begin
            // result side first: an output in this cycle belongs to an older transfer
            if (i_out_valid && i_out_ready) begin
                if (due_results.size() == 0) begin
                    $error("unexpected result: status %0d count %0d word %h",
                           i_status, i_entry_count, i_read_word);
                    fail_count++;
                end else begin
                    want = due_results.pop_front();
                    if (i_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, i_status);
                        fail_count++;
                    end
                    if (i_entry_count !== want.count) begin
                        $error("entry_count: expected %0d, got %0d",
                               want.count, i_entry_count);
                        fail_count++;
                    end
                    if (i_read_word !== want.word) begin
                        $error("read_word: expected %h, got %h", want.word, i_read_word);
                        fail_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                due_results.push_back(apply_list_op(t_mode'(i_mode), int'(i_position),
                                                    i_item_word));
        end
        o_fail_count  = fail_count;
        o_results_due = due_results.size();
        o_list_len    = list_len;
    end

endmodule

[tb/sv/positional_array_list_tb.sv]
// ----------------------------------------------------------------------------
// positional_array_list_tb: top level of the list testbench
// Drives a directed pass over the edge cases, then randomized sessions that
// grow, drain, churn or fill the list, with random gaps on the input side
// and random backpressure on the output side. Checking is done by
// pal_list_checker; this module only makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module positional_array_list_tb;

    import pal_pkg::*;

    localparam int ITEM_TARGET    = 600;
    localparam int WATCHDOG_LIMIT = 5000;

    typedef enum int {PROF_GROW, PROF_SHRINK, PROF_CHURN, PROF_FILL} t_profile;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [MODE_BITS-1:0]  mode = '0;
    logic [POS_BITS-1:0]   position = '0;
    logic [ITEM_BITS-1:0]  item_word = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [STAT_BITS-1:0]  status;
    logic [COUNT_BITS-1:0] entry_count;
    logic [ITEM_BITS-1:0]  read_word;

    int fail_count;
    int results_due;
    int list_len;
    int random_count = 0;
    int stall_run = 0;
    int ready_hold = 0;
    int ready_roll;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    positional_array_list u_top (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_mode        (mode),
        .i_position    (position),
        .i_item_word   (item_word),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_status      (status),
        .o_entry_count (entry_count),
        .o_read_word   (read_word)
    );

    pal_list_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_mode        (mode),
        .i_position    (position),
        .i_item_word   (item_word),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_status      (status),
        .i_entry_count (entry_count),
        .i_read_word   (read_word),
        .o_fail_count  (fail_count),
        .o_results_due (results_due),
        .o_list_len    (list_len)
    );

    // output backpressure: mostly ready, short stalls, now and then a long one
    always @(negedge clk) begin
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else begin
            ready_roll = $urandom_range(0, 99);
            if (ready_roll < 55) begin
                out_ready  <= 1'b1;
                ready_hold <= $urandom_range(0, 15);
            end else if (ready_roll < 65) begin
                out_ready  <= 1'b1;
                ready_hold <= $urandom_range(60, 150);
            end else if (ready_roll < 92) begin
                out_ready  <= 1'b0;
                ready_hold <= $urandom_range(0, 2);
            end else begin
                out_ready  <= 1'b0;
                ready_hold <= $urandom_range(10, 40);
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            stall_run <= 0;
        end else if (stall_run + 1 >= WATCHDOG_LIMIT) begin
            $display("positional_array_list_tb: errors");
            $finish;
        end else begin
            stall_run <= stall_run + 1;
        end
    end

    // entered just after a falling edge; returns at the falling edge after the transfer
    task automatic send_item(t_mode op, int pos, logic [ITEM_BITS-1:0] word);
        in_valid  <= 1'b1;
        mode      <= op;
        position  <= pos[POS_BITS-1:0];
        item_word <= word;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic hold_off(int n);
        repeat (n) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
    endtask

    function automatic int pick_gap(bit busy);
        int r;
        r = $urandom_range(0, 99);
        if (busy || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic t_mode pick_mode(t_profile prof);
        int r;
        r = $urandom_range(0, 99);
        case (prof)
            PROF_GROW: begin
                if (r < 35) return MODE_PUSH_BACK;
                if (r < 55) return MODE_PUSH_FRONT;
                if (r < 80) return MODE_INSERT;
                if (r < 87) return MODE_READ;
                if (r < 92) return MODE_ERASE;
                if (r < 96) return MODE_POP_BACK;
                return MODE_POP_FRONT;
            end
            PROF_SHRINK: begin
                if (r < 25) return MODE_ERASE;
                if (r < 45) return MODE_POP_BACK;
                if (r < 65) return MODE_POP_FRONT;
                if (r < 80) return MODE_READ;
                if (r < 90) return MODE_PUSH_BACK;
                if (r < 97) return MODE_INSERT;
                return MODE_CLEAR;
            end
            PROF_FILL: begin
                if (r < 40) return MODE_PUSH_BACK;
                if (r < 70) return MODE_PUSH_FRONT;
                return MODE_INSERT;
            end
            default: begin
                if (r < 3) return MODE_CLEAR;
                return t_mode'($urandom_range(0, 6));
            end
        endcase
    endfunction

    // mostly legal positions, some on the boundary, some anywhere in the field
    function automatic int pick_pos(t_mode op);
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) begin
            if (op == MODE_INSERT) return $urandom_range(0, list_len);
            return (list_len > 0) ? $urandom_range(0, list_len - 1) : 0;
        end
        if (r < 90) return list_len + $urandom_range(0, 1);
        return $urandom_range(0, 127);
    endfunction

    function automatic logic [ITEM_BITS-1:0] pick_word();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return '0;
        if (r < 20) return '1;
        return $urandom;
    endfunction

    task automatic random_item(t_profile prof, bit busy);
        t_mode op;
        hold_off(pick_gap(busy));
        op = pick_mode(prof);
        send_item(op, pick_pos(op), pick_word());
        random_count++;
    endtask

    task automatic directed_item(t_mode op, int pos, logic [ITEM_BITS-1:0] word);
        hold_off(pick_gap(1'b0));
        send_item(op, pos, word);
    endtask

    initial begin
        t_profile prof;
        bit       busy;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // every removal and read on an empty list, inserts past the end
        directed_item(MODE_CLEAR,      0,   '0);
        directed_item(MODE_POP_BACK,   0,   '0);
        directed_item(MODE_POP_FRONT,  0,   '0);
        directed_item(MODE_ERASE,      0,   '0);
        directed_item(MODE_READ,       0,   '0);
        directed_item(MODE_INSERT,     1,   32'h1111_1111);
        directed_item(MODE_INSERT,     127, 32'h2222_2222);
        // build a five-entry list through every write path
        directed_item(MODE_PUSH_BACK,  0,   32'hFFFF_FFFF);
        directed_item(MODE_PUSH_FRONT, 0,   32'h0000_0000);
        directed_item(MODE_INSERT,     0,   32'hA5A5_A5A5);
        directed_item(MODE_INSERT,     3,   32'h5A5A_5A5A);
        directed_item(MODE_INSERT,     2,   32'h1234_5678);
        for (int p = 0; p < 5; p++) directed_item(MODE_READ, p, '0);
        directed_item(MODE_READ,       5,   '0);
        directed_item(MODE_READ,       64,  '0);
        directed_item(MODE_ERASE,      5,   '0);
        directed_item(MODE_ERASE,      2,   '0);
        directed_item(MODE_POP_BACK,   0,   '0);
        directed_item(MODE_POP_FRONT,  0,   '0);
        directed_item(MODE_READ,       0,   '0);
        directed_item(MODE_CLEAR,      0,   '0);

        // drain everything before the random part starts
        in_valid <= 1'b0;
        while (results_due != 0) @(negedge clk);

        while (random_count < ITEM_TARGET) begin
            prof = t_profile'($urandom_range(0, 3));
            busy = ($urandom_range(0, 3) == 0);
            if (prof == PROF_FILL) begin
                while (list_len < CAPACITY) random_item(PROF_FILL, busy);
                // writes against a full list
                repeat (6) random_item(PROF_FILL, busy);
            end else begin
                repeat ($urandom_range(20, 60)) random_item(prof, busy);
            end
        end

        hold_off(1);
        while (results_due != 0) @(negedge clk);
        repeat (20) @(negedge clk);
        if (fail_count == 0 && results_due == 0)
            $display("positional_array_list_tb: clean");
        else
            $display("positional_array_list_tb: errors");
        $finish;
    end

endmodule
